/* hw/rtl/pct_pkg.sv */
// pct_pkg: shared types, constants and character helpers for the percent codec.
// No dependencies; used by every module in hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

    // Character constants
    localparam logic [7:0] PCT_CHAR   = 8'h25;  // '%'
    localparam logic [7:0] DASH_CHAR  = 8'h2D;  // '-'
    localparam logic [7:0] DOT_CHAR   = 8'h2E;  // '.'
    localparam logic [7:0] UNDER_CHAR = 8'h5F;  // '_'
    localparam logic [7:0] TILDE_CHAR = 8'h7E;  // '~'
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input and output items
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // One command: one to three bytes, last flag applies to the final byte
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            last;
    } t_cmd;

    // Decoder hold state
    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_PCT   = 3'b010,
        PEND_DIGIT = 3'b100
    } t_pend_state;

    function automatic logic is_unreserved(input logic [7:0] b);
        logic r;
        r = ((b >= 8'h41) && (b <= 8'h5A)) ||
            ((b >= 8'h61) && (b <= 8'h7A)) ||
            ((b >= 8'h30) && (b <= 8'h39)) ||
            (b == DASH_CHAR) || (b == DOT_CHAR) ||
            (b == UNDER_CHAR) || (b == TILDE_CHAR);
        return r;
    endfunction

    // Bit 4 set means not a hex digit; bits 3:0 hold the value otherwise
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            r = {1'b0, 4'(b - 8'h30)};
        end else if ((b >= 8'h41) && (b <= 8'h46)) begin
            r = {1'b0, 4'(b - 8'h37)};
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            r = {1'b0, 4'(b - 8'h57)};
        end else begin
            r = 5'h10;
        end
        return r;
    endfunction

    // Uppercase hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pct_front.sv */
// pct_front: accepts input items, holds the mode register and the decoder
// escape state, and turns each item into a command of one to three bytes,
// or into none while a decode escape is held. Depends on pct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pct_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_wdata,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  pct_pkg::t_in_item i_in_item,
    output logic              o_push,
    output pct_pkg::t_cmd     o_cmd,
    input  wire               i_q_ready
);

    logic                 r_mode;
    pct_pkg::t_pend_state r_state, n_state;
    logic [7:0]           r_digit, n_digit;

    logic       w_accept;
    logic [7:0] w_b;
    logic       w_last;
    logic       w_hold;
    logic [4:0] w_hex_in;
    logic [4:0] w_hex_held;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;
    assign w_b        = i_in_item.in_byte;
    assign w_last     = i_in_item.in_last;
    assign w_hold     = (w_b == pct_pkg::PCT_CHAR) && !w_last;
    assign w_hex_in   = pct_pkg::hex_value(w_b);
    assign w_hex_held = pct_pkg::hex_value(r_digit);

    // Classify the item: command bytes and next hold state
    always_comb begin
        n_state      = r_state;
        n_digit      = r_digit;
        o_cmd.cnt    = 2'd0;
        o_cmd.bytes  = '0;
        o_cmd.last   = w_last;
        if (r_mode == pct_pkg::MODE_ENCODE) begin
            if (pct_pkg::is_unreserved(w_b)) begin
                o_cmd.cnt      = 2'd1;
                o_cmd.bytes[0] = w_b;
            end else begin
                o_cmd.cnt      = 2'd3;
                o_cmd.bytes[0] = pct_pkg::PCT_CHAR;
                o_cmd.bytes[1] = pct_pkg::hex_char(w_b[7:4]);
                o_cmd.bytes[2] = pct_pkg::hex_char(w_b[3:0] & pct_pkg::NIBBLE_MASK);
            end
        end else begin
            unique case (r_state)
                pct_pkg::PEND_PCT: begin
                    if (!w_hex_in[4] && !w_last) begin
                        n_state = pct_pkg::PEND_DIGIT;
                        n_digit = w_b;
                    end else if (w_hold) begin
                        o_cmd.cnt      = 2'd1;
                        o_cmd.bytes[0] = pct_pkg::PCT_CHAR;
                    end else begin
                        n_state        = pct_pkg::PEND_NONE;
                        o_cmd.cnt      = 2'd2;
                        o_cmd.bytes[0] = pct_pkg::PCT_CHAR;
                        o_cmd.bytes[1] = w_b;
                    end
                end
                pct_pkg::PEND_DIGIT: begin
                    o_cmd.bytes[0] = pct_pkg::PCT_CHAR;
                    o_cmd.bytes[1] = r_digit;
                    if (!w_hex_in[4]) begin
                        n_state        = pct_pkg::PEND_NONE;
                        o_cmd.cnt      = 2'd1;
                        o_cmd.bytes[0] = {w_hex_held[3:0], w_hex_in[3:0]};
                    end else if (w_hold) begin
                        n_state   = pct_pkg::PEND_PCT;
                        o_cmd.cnt = 2'd2;
                    end else begin
                        n_state        = pct_pkg::PEND_NONE;
                        o_cmd.cnt      = 2'd3;
                        o_cmd.bytes[2] = w_b;
                    end
                end
                default: begin
                    if (w_hold) begin
                        n_state = pct_pkg::PEND_PCT;
                    end else begin
                        n_state        = pct_pkg::PEND_NONE;
                        o_cmd.cnt      = 2'd1;
                        o_cmd.bytes[0] = w_b;
                    end
                end
            endcase
            // End of string leaves nothing held
            if (w_last) begin
                n_state = pct_pkg::PEND_NONE;
            end
        end
    end

    assign o_push = w_accept && (o_cmd.cnt != 2'd0);

    // Mode register and hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pct_pkg::MODE_ENCODE;
            r_state <= pct_pkg::PEND_NONE;
        end else if (i_cfg_we) begin
            r_mode  <= i_cfg_wdata;
            r_state <= pct_pkg::PEND_NONE;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Held digit, payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_digit <= n_digit;
        end
    end

    // Encode mode never holds a byte
    a_encode_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == pct_pkg::MODE_ENCODE) |-> (r_state == pct_pkg::PEND_NONE))
        else $error("front holds bytes in encode mode");

    // A final byte always yields output and leaves nothing held
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |-> (o_cmd.cnt != 2'd0))
        else $error("final byte produced no command");

    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_state == pct_pkg::PEND_NONE))
        else $error("hold state survived end of string");

endmodule

`default_nettype wire

/* hw/rtl/pct_queue.sv */
// pct_queue: small first-in first-out queue of commands between front and back.
// Depends on pct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pct_queue #(
    parameter int DEPTH = pct_pkg::QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  pct_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  wire           i_pop,
    output logic          o_valid,
    output pct_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    pct_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* hw/rtl/pct_back.sv */
// pct_back: takes commands from the queue and emits their bytes, one output
// item per cycle while output is ready, from a registered command. Uses pct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pct_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_q_valid,
    input  pct_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output pct_pkg::t_out_item o_out_item
);

    logic          r_busy;
    logic [1:0]    r_idx;
    pct_pkg::t_cmd r_cmd;

    logic w_at_end;
    logic w_take;

    assign w_at_end = (r_idx == (r_cmd.cnt - 2'd1));
    assign w_take   = r_busy && i_out_ready;
    assign o_pop    = i_q_valid && (!r_busy || (w_take && w_at_end));

    assign o_out_valid         = r_busy;
    assign o_out_item.out_byte = r_cmd.bytes[r_idx];
    assign o_out_item.out_last = r_cmd.last && w_at_end;

    // Busy flag and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_take) begin
            if (w_at_end) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Current command, payload only
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_cmd.cnt != 2'd0) && (r_idx < r_cmd.cnt)))
        else $error("byte index past end of command");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_at_end) |=> (r_busy && (r_idx == $past(r_idx) + 2'd1)))
        else $error("byte index did not advance");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == 2'd0))
        else $error("idle back end with nonzero index");

endmodule

`default_nettype wire

/* hw/rtl/percent_codec_top.sv */
// percent_codec_top: URI percent encoder/decoder, front classifier, command
// queue and byte emitter. Depends on pct_pkg, pct_front, pct_queue, pct_back.
//
//   Channel  Direction  Signals                                   Handshake
//   input    in         i_in_valid, o_in_ready, i_in_item         valid/ready
//   output   out        o_out_valid, i_out_ready, o_out_item      valid/ready
//   config   in         i_cfg_we, i_cfg_wdata (mode)              write enable
//
// The front takes one item per cycle while the queue has room; the back emits one
// output item per cycle while the output is ready; an item yields 0 to 3 bytes:
// none while an escape is held, 3 for an encoded byte, 1 to 3 for a broken escape.
// Each command is registered in the queue, then in the back, before it is output.
// Reset clears the mode to encode, the hold state, the queue and the emitter.
// An output stall fills the queue, then drops o_in_ready.
`timescale 1ns / 1ps
`default_nettype none

module percent_codec_top #(
    parameter int QUEUE_DEPTH = pct_pkg::QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_wdata,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  pct_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output pct_pkg::t_out_item o_out_item
);

    logic          w_push;
    logic          w_pop;
    logic          w_q_ready;
    logic          w_q_valid;
    pct_pkg::t_cmd w_front_cmd;
    pct_pkg::t_cmd w_q_cmd;

    pct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd),
        .i_q_ready   (w_q_ready)
    );

    pct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    pct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
